[hdl/barometric_pressure_compensation_macros.svh]
// assertion macros for the pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
// implication checked on every clock outside reset
`define BPC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define BPC_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/bpc_pkg.sv]
// shared types and constants of the pressure compensation block
`default_nettype none
package bpc_pkg;
    localparam int unsigned NumDivStages = 32;
    // sideband width of each divider: x1, sign, zero flag and raw pressure of the first divide
    localparam int unsigned DivSideWidth = 32 + 1 + 1 + 16;
    localparam logic [1:0] RegCalA = 2'd0;
    localparam logic [1:0] RegCalB = 2'd1;
    localparam logic [1:0] RegCalC = 2'd2;
    localparam logic [1:0] RegOffset = 2'd3;

    typedef struct packed {
        logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, off;
        logic [31:0] ac4, ac5, ac6;
    } t_cal;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_press;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic signed [31:0] press_pa;
        logic div_error;
    } t_out;

    // one restoring step of an unsigned divide
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
    } t_div;

    function automatic t_div div_step(t_div d);
        logic [32:0] trial;
        t_div r;
        trial = {d.rem, d.quo[31]} - {1'b0, d.den};
        r.den = d.den;
        if (!trial[32]) begin
            r.rem = trial[31:0];
            r.quo = {d.quo[30:0], 1'b1};
        end else begin
            r.rem = {d.rem[30:0], d.quo[31]};
            r.quo = {d.quo[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] asr(logic [31:0] v, int unsigned s);
        return 32'($signed(v) >>> s);
    endfunction
endpackage
`default_nettype wire

[hdl/bpc_stream_if.sv]
// valid/ready channel with a typed payload
`default_nettype none
interface bpc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/barometric_pressure_compensation.sv]
// top level of the pressure compensation pipeline
//  channel | dir | payload
//  i_in    | in  | raw_temp[15:0], raw_press[15:0]
//  o_out   | out | temp_tenths[15:0] s, press_pa[31:0] s, div_error
//  cfg     | in  | i_cfg_we, i_cfg_index[1:0], i_cfg_data[63:0]
// one item enters per cycle while the output stage is empty or being taken; a result
// passes two 32-stage bit-per-stage dividers in series (temperature, pressure)
// synchronous active-low reset clears valid bits and the calibration registers
// the whole pipe advances only when the output stage is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated
`default_nettype none
`include "barometric_pressure_compensation_macros.svh"
module barometric_pressure_compensation import bpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    bpc_stream_if.sink       i_in,
    bpc_stream_if.source     o_out
);
    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [15:0] r_off;
    t_cal cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0; r_cal_b <= '0; r_cal_c <= '0; r_off <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegCalA:   r_cal_a <= i_cfg_data;
                RegCalB:   r_cal_b <= i_cfg_data;
                RegCalC:   r_cal_c <= i_cfg_data[31:0];
                RegOffset: r_off   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.ac1 = 32'(signed'(r_cal_a[63:48]));
        cal.ac2 = 32'(signed'(r_cal_a[47:32]));
        cal.ac3 = 32'(signed'(r_cal_a[31:16]));
        cal.ac4 = {16'd0, r_cal_a[15:0]};
        cal.ac5 = {16'd0, r_cal_b[63:48]};
        cal.ac6 = {16'd0, r_cal_b[47:32]};
        cal.b1  = 32'(signed'(r_cal_b[31:16]));
        cal.b2  = 32'(signed'(r_cal_b[15:0]));
        cal.mc  = 32'(signed'(r_cal_c[31:16]));
        cal.md  = 32'(signed'(r_cal_c[15:0]));
        cal.off = 32'(signed'(r_off));
    end

    // global enable: output register empty or being drained
    logic en;
    logic r_ov;
    t_out r_od;
    assign en = !r_ov || o_out.ready;
    assign i_in.ready = en;

    // stage 1: temperature product
    logic r1_v; logic [31:0] r1_prod; logic [15:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_in.valid;
        if (en) begin
            r1_prod <= ({16'd0, i_in.data.raw_temp} - cal.ac6) * cal.ac5;
            r1_up   <= i_in.data.raw_press;
        end
    end

    // stage 2: x1, divisor, signs
    logic r2_v; logic [31:0] r2_x1, r2_n, r2_d; logic r2_neg, r2_z; logic [15:0] r2_up;
    logic [31:0] s2_x1, s2_den, s2_num;
    always_comb begin
        s2_x1  = asr(r1_prod, 15);
        s2_den = s2_x1 + cal.md;
        s2_num = cal.mc << 11;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_x1  <= s2_x1;
            r2_z   <= (s2_den == 32'd0);
            r2_neg <= s2_num[31] ^ s2_den[31];
            r2_n   <= s2_num[31] ? -s2_num : s2_num;
            r2_d   <= s2_den[31] ? -s2_den : s2_den;
            r2_up  <= r1_up;
        end
    end

    // first divide: x2 = (mc << 11) / (x1 + md)
    logic d1_v; logic [31:0] d1_q; logic [DivSideWidth-1:0] d1_s;
    bpc_divider u_div_t (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r2_v),
        .i_num(r2_n), .i_den(r2_z ? 32'd1 : r2_d),
        .i_side({r2_x1, r2_neg, r2_z, r2_up}),
        .o_valid(d1_v), .o_quo(d1_q), .o_side(d1_s)
    );

    // stage 3: b5, b6, t
    logic r3_v, r3_z; logic [31:0] r3_b6, r3_t; logic [15:0] r3_up;
    logic [31:0] s3_b5;
    assign s3_b5 = d1_s[49:18] + (d1_s[17] ? -d1_q : d1_q);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= d1_v;
        if (en) begin
            r3_z  <= d1_s[16];
            r3_up <= d1_s[15:0];
            r3_b6 <= s3_b5 - 32'd4000;
            r3_t  <= asr(s3_b5 + 32'd8, 4);
        end
    end

    // stage 4: b6 squared and linear products
    logic r4_v, r4_z; logic [31:0] r4_sqp, r4_a2, r4_a3, r4_t; logic [15:0] r4_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
        if (en) begin
            r4_sqp <= r3_b6 * r3_b6;
            r4_a2  <= cal.ac2 * r3_b6;
            r4_a3  <= cal.ac3 * r3_b6;
            r4_z <= r3_z; r4_up <= r3_up; r4_t <= r3_t;
        end
    end

    // stage 5: products with sq
    logic r5_v, r5_z; logic [31:0] r5_p2, r5_p1, r5_a2, r5_a3, r5_t; logic [15:0] r5_up;
    logic [31:0] s5_sq;
    assign s5_sq = asr(r4_sqp, 12);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
        if (en) begin
            r5_p2 <= cal.b2 * s5_sq;
            r5_p1 <= cal.b1 * s5_sq;
            r5_a2 <= r4_a2; r5_a3 <= r4_a3;
            r5_z <= r4_z; r5_up <= r4_up; r5_t <= r4_t;
        end
    end

    // stage 6: b3 and x3
    logic r6_v, r6_z; logic [31:0] r6_b3, r6_x3, r6_t; logic [15:0] r6_up;
    logic [31:0] s6_n3, s6_x3;
    always_comb begin
        s6_n3 = cal.ac1 * 32'd4 + asr(r5_p2, 11) + asr(r5_a2, 11) + 32'd2;
        s6_x3 = asr(asr(r5_a3, 13) + asr(r5_p1, 16) + 32'd2, 2);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
        if (en) begin
            // signed divide by four, truncating toward zero
            r6_b3 <= asr(s6_n3 + (s6_n3[31] ? 32'd3 : 32'd0), 2);
            r6_x3 <= s6_x3 + 32'd32768;
            r6_z <= r5_z; r6_up <= r5_up; r6_t <= r5_t;
        end
    end

    // stage 7: b4 product and b7 difference
    logic r7_v, r7_z; logic [31:0] r7_b4p, r7_diff, r7_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
        if (en) begin
            r7_b4p  <= cal.ac4 * r6_x3;
            r7_diff <= {16'd0, r6_up} - r6_b3;
            r7_z <= r6_z; r7_t <= r6_t;
        end
    end

    // stage 8: b7 and division operands
    logic r8_v, r8_z, r8_big; logic [31:0] r8_b7, r8_b4, r8_t;
    logic [31:0] s8_b4;
    assign s8_b4 = r7_b4p >> 15;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= r7_v;
        if (en) begin
            r8_b7 <= r7_diff * 32'd50000;
            r8_b4 <= s8_b4;
            r8_z  <= r7_z || (s8_b4 == 32'd0);
            r8_t  <= r7_t;
        end
    end

    // second divide: p
    logic d2_v; logic [31:0] d2_q; logic [DivSideWidth-1:0] d2_s;
    logic r8_bign;
    assign r8_bign = r8_b7[31];
    bpc_divider u_div_p (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r8_v),
        .i_num(r8_bign ? r8_b7 : r8_b7 << 1), .i_den(r8_z ? 32'd1 : r8_b4),
        .i_side({16'd0, r8_t, r8_bign, r8_z}),
        .o_valid(d2_v), .o_quo(d2_q), .o_side(d2_s)
    );
    assign r8_big = r8_bign;

    // stage 9: p and its square
    logic r9_v, r9_z; logic [31:0] r9_p, r9_sq, r9_t;
    logic [31:0] s9_p, s9_h;
    always_comb begin
        s9_p = d2_s[1] ? d2_q << 1 : d2_q;
        s9_h = asr(s9_p, 8);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en) r9_v <= d2_v;
        if (en) begin
            r9_p <= s9_p; r9_sq <= s9_h * s9_h;
            r9_z <= d2_s[0]; r9_t <= d2_s[33:2];
        end
    end

    // stage 10: correction products
    logic r10_v, r10_z; logic [31:0] r10_p, r10_m1, r10_m2, r10_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (en) r10_v <= r9_v;
        if (en) begin
            r10_m1 <= r9_sq * 32'd3038;
            r10_m2 <= (32'd0 - 32'd7357) * r9_p;
            r10_p <= r9_p; r10_z <= r9_z; r10_t <= r9_t;
        end
    end

    // output register with saturation and zero-divisor forcing
    t_out s_res;
    logic [31:0] s_pf;
    always_comb begin
        s_pf = r10_p + asr(asr(r10_m1, 16) + asr(r10_m2, 16) + 32'd3791, 4) + cal.off;
        s_res.div_error = r10_z;
        if (r10_z) begin
            s_res.temp_tenths = '0;
            s_res.press_pa = '0;
        end else begin
            s_res.press_pa = s_pf;
            if ($signed(r10_t) > 32'sd32767) s_res.temp_tenths = 16'sh7fff;
            else if ($signed(r10_t) < -32'sd32768) s_res.temp_tenths = 16'sh8000;
            else s_res.temp_tenths = r10_t[15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r10_v;
        if (en) r_od <= s_res;
    end
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    `BPC_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_ov && !o_out.ready, r_ov && $stable(r_od))
    `BPC_ASSERT_IMP(a_ready_en, i_clk, i_rst_n, !r_ov, i_in.ready)
    `BPC_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_ov && r_od.div_error,
        r_od.press_pa == 32'd0 && r_od.temp_tenths == 16'd0)
    `BPC_ASSERT_IMP(a_big_shift, i_clk, i_rst_n, r8_v && r8_big, r8_b7[31])
endmodule
`default_nettype wire

[hdl/bpc_divider.sv]
// pipelined unsigned divider, one quotient bit per stage, with sideband
`default_nettype none
module bpc_divider import bpc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [31:0]             i_num,
    input  wire logic [31:0]             i_den,
    input  wire logic [DivSideWidth-1:0] i_side,
    output logic                         o_valid,
    output logic [31:0]                  o_quo,
    output logic [DivSideWidth-1:0]      o_side
);
    t_div                    r_st [NumDivStages];
    logic [DivSideWidth-1:0] r_sd [NumDivStages];
    logic [NumDivStages-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NumDivStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step('{rem: 32'd0, quo: i_num, den: i_den});
            r_sd[0] <= i_side;
            for (int k = 1; k < NumDivStages; k++) begin
                r_st[k] <= div_step(r_st[k-1]);
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_valid = r_v[NumDivStages-1];
    assign o_quo   = r_st[NumDivStages-1].quo;
    assign o_side  = r_sd[NumDivStages-1];
endmodule
`default_nettype wire

[tb/tb.sv]
// testbench for the barometric pressure compensation pipeline
`default_nettype none
module tb import bpc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // allow generous margin at the end for the block's pipeline to drain
    localparam int unsigned DrainCycles = 200;
    localparam int unsigned NumRandom = 1500;

    typedef struct {
        logic [63:0] cal_a;
        logic [63:0] cal_b;
        logic [31:0] cal_c;
        logic [15:0] offset;
    } t_settings;

    // directed row: input item plus an optional typed-in expectation
    typedef struct {
        logic [15:0] raw_temp;
        logic [15:0] raw_press;
        bit          known;
        t_out        want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    bpc_stream_if #(.T(t_in))  in_ch ();
    bpc_stream_if #(.T(t_out)) out_ch ();

    barometric_pressure_compensation i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // predictor copy of the calibration registers
    t_settings cal_now;
    t_out      pending_readings[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned errors_seen;
    int unsigned items_sent;

    // receiver hold-off control
    bit long_stall_req;
    bit long_stall_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // end the run after a generous fixed time
    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_readings.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] shr_arith(logic [31:0] v, int unsigned s);
        return 32'($signed(v) >>> s);
    endfunction

    // signed 32-bit divide truncating toward zero, divisor nonzero
    function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
        logic [31:0] mn, mdv, q;
        mn  = n[31] ? -n : n;
        mdv = d[31] ? -d : d;
        q   = mn / mdv;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    // compensated temperature and pressure for one reading pair
    function automatic t_out compensate(t_settings c, logic [15:0] ut16,
                                        logic [15:0] up16);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, off;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t;
        t_out r;
        ac1 = sext16(c.cal_a[63:48]);
        ac2 = sext16(c.cal_a[47:32]);
        ac3 = sext16(c.cal_a[31:16]);
        ac4 = {16'd0, c.cal_a[15:0]};
        ac5 = {16'd0, c.cal_b[63:48]};
        ac6 = {16'd0, c.cal_b[47:32]};
        b1  = sext16(c.cal_b[31:16]);
        b2  = sext16(c.cal_b[15:0]);
        mc  = sext16(c.cal_c[31:16]);
        md  = sext16(c.cal_c[15:0]);
        off = sext16(c.offset);
        ut  = {16'd0, ut16};
        up  = {16'd0, up16};
        r.temp_tenths = '0;
        r.press_pa    = '0;
        r.div_error   = 1'b1;
        x1 = shr_arith((ut - ac6) * ac5, 15);
        if (x1 + md == 32'd0) return r;
        x2 = div_trunc(mc << 11, x1 + md);
        b5 = x1 + x2;
        t  = shr_arith(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = shr_arith(b6 * b6, 12);
        x1 = shr_arith(b2 * sq, 11);
        x2 = shr_arith(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_trunc(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
        x1 = shr_arith(ac3 * b6, 13);
        x2 = shr_arith(b1 * sq, 16);
        x3 = shr_arith(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 32'd0) return r;
        b7 = (up - b3) * 32'd50000;
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = shr_arith(p, 8);
        x1 = x1 * x1;
        x1 = shr_arith(x1 * 32'd3038, 16);
        x2 = shr_arith(-32'd7357 * p, 16);
        p  = p + shr_arith(x1 + x2 + 32'd3791, 4) + off;
        // saturate temperature to 16 bits
        if ($signed(t) > 32767) r.temp_tenths = 16'sh7fff;
        else if ($signed(t) < -32768) r.temp_tenths = 16'sh8000;
        else r.temp_tenths = t[15:0];
        r.press_pa  = p;
        r.div_error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            RegCalA:   cal_now.cal_a  = val;
            RegCalB:   cal_now.cal_b  = val;
            RegCalC:   cal_now.cal_c  = val[31:0];
            RegOffset: cal_now.offset = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(t_settings s);
        write_reg(RegCalA, s.cal_a);
        write_reg(RegCalB, s.cal_b);
        write_reg(RegCalC, {32'd0, s.cal_c});
        write_reg(RegOffset, {48'd0, s.offset});
    endtask

    // wait until every expected result has come back, plus pipeline margin
    task automatic drain();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // offer one item, hold valid until accepted
    task automatic send_reading(logic [15:0] ut, logic [15:0] up, bit known, t_out want);
        t_out exp_r;
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 9) < 4) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{raw_temp: ut, raw_press: up};
        exp_r = compensate(cal_now, ut, up);
        if (known && exp_r != want)
            report_mismatch("typed-in expectation", {15'd0, exp_r}, {15'd0, want});
        do @(posedge i_clk); while (!in_ch.ready);
        pending_readings.push_back(exp_r);
        items_sent++;
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned wait_n;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_stall_req && !long_stall_done) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_stall_done = 1'b1;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 9) < 4) wait_n = 0;
            if (wait_n != 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected result item", {15'd0, out_ch.data}, 64'd0);
            end else begin
                want = pending_readings.pop_front();
                if (out_ch.data.div_error) errors_seen++;
                if (out_ch.data.temp_tenths !== want.temp_tenths)
                    report_mismatch("temp_tenths", {48'd0, out_ch.data.temp_tenths},
                                    {48'd0, want.temp_tenths});
                if (out_ch.data.press_pa !== want.press_pa)
                    report_mismatch("press_pa", {32'd0, out_ch.data.press_pa},
                                    {32'd0, want.press_pa});
                if (out_ch.data.div_error !== want.div_error)
                    report_mismatch("div_error", {63'd0, out_ch.data.div_error},
                                    {63'd0, want.div_error});
            end
        end
    end

    // stimulus
    initial begin
        t_settings datasheet, zero_s, ones_s, extreme_s, rand_s;
        t_row rows[$];
        t_out z, e;
        logic [15:0] ut, up;
        int unsigned n;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = RegCalA;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cal_now     = '{cal_a: '0, cal_b: '0, cal_c: '0, offset: '0};
        mismatches = 0; results_seen = 0; errors_seen = 0; items_sent = 0;
        long_stall_req = 1'b0; long_stall_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset all coefficients are zero: x1 + md is zero, divide error
        z = '{temp_tenths: '0, press_pa: '0, div_error: 1'b1};
        rows.push_back('{16'h0000, 16'h0000, 1'b1, z});
        rows.push_back('{16'hffff, 16'hffff, 1'b1, z});
        rows.push_back('{16'h8000, 16'h7fff, 1'b1, z});
        foreach (rows[i]) send_reading(rows[i].raw_temp, rows[i].raw_press,
                                       rows[i].known, rows[i].want);
        idle_input();
        drain();

        // typical calibration words of this sensor family
        datasheet.cal_a  = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
        datasheet.cal_b  = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
        datasheet.cal_c  = {-16'sd8711, 16'sd2868};
        datasheet.offset = 16'sd0;
        load_settings(datasheet);
        rows.delete();
        e = '{temp_tenths: 16'sd150, press_pa: 32'sd69964, div_error: 1'b0};
        rows.push_back('{16'd27898, 16'd23843, 1'b1, e});
        rows.push_back('{16'h0000, 16'h0000, 1'b0, z});
        rows.push_back('{16'hffff, 16'hffff, 1'b0, z});
        rows.push_back('{16'h8000, 16'h8000, 1'b0, z});
        rows.push_back('{16'h7fff, 16'h7fff, 1'b0, z});
        rows.push_back('{16'h5555, 16'haaaa, 1'b0, z});
        rows.push_back('{16'haaaa, 16'h5555, 1'b0, z});
        foreach (rows[i]) send_reading(rows[i].raw_temp, rows[i].raw_press,
                                       rows[i].known, rows[i].want);
        idle_input();
        drain();

        // md cancels x1 at ac5 zero: divide error from the temperature stage
        zero_s = datasheet;
        zero_s.cal_b[63:48] = 16'd0;
        zero_s.cal_c[15:0]  = 16'd0;
        load_settings(zero_s);
        send_reading(16'd1234, 16'd4321, 1'b1, z);
        // ac4 zero: b4 is zero, divide error from the pressure stage
        zero_s = datasheet;
        zero_s.cal_a[15:0] = 16'd0;
        idle_input();
        drain();
        load_settings(zero_s);
        send_reading(16'd27898, 16'd23843, 1'b1, z);
        send_reading(16'hffff, 16'h0000, 1'b1, z);
        idle_input();
        drain();

        // all-ones and extreme coefficients, offset extremes, saturation
        ones_s = '{cal_a: '1, cal_b: '1, cal_c: '1, offset: 16'h8000};
        extreme_s = '{cal_a: 64'h7fff_8000_7fff_ffff, cal_b: 64'hffff_0000_8000_7fff,
                      cal_c: 32'h7fff_0001, offset: 16'h7fff};
        load_settings(ones_s);
        for (int i = 0; i < 4; i++)
            send_reading(i[0] ? 16'hffff : 16'h0000, i[1] ? 16'hffff : 16'h0000, 1'b0, z);
        idle_input();
        drain();
        load_settings(extreme_s);
        for (int i = 0; i < 4; i++)
            send_reading(i[0] ? 16'hffff : 16'h0001, i[1] ? 16'hffff : 16'h0000, 1'b0, z);
        idle_input();
        drain();

        // random phases: mostly near-typical calibrations, some fully random
        for (int ph = 0; ph < 6; ph++) begin
            rand_s = datasheet;
            if (ph % 3 == 2) begin
                rand_s.cal_a = {$urandom, $urandom};
                rand_s.cal_b = {$urandom, $urandom};
                rand_s.cal_c = $urandom;
            end else begin
                rand_s.cal_a[15:0]  = 16'($urandom_range(20000, 40000));
                rand_s.cal_b[63:48] = 16'($urandom_range(20000, 40000));
                rand_s.cal_b[47:32] = 16'($urandom_range(15000, 30000));
                rand_s.cal_c[15:0]  = 16'($urandom_range(2000, 4000));
            end
            rand_s.offset = 16'($urandom);
            load_settings(rand_s);
            // long receiver hold-off while the sender keeps offering
            if (ph == 1) long_stall_req = 1'b1;
            for (n = 0; n < NumRandom / 6; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    ut = 16'($urandom_range(20000, 35000));
                    up = 16'($urandom_range(15000, 45000));
                end else begin
                    ut = 16'($urandom);
                    up = 16'($urandom);
                end
                send_reading(ut, up, 1'b0, z);
                // sender pause until everything has come back
                if (ph == 3 && n == 100) begin
                    idle_input();
                    while (pending_readings.size() != 0) @(posedge i_clk);
                end
            end
            idle_input();
            drain();
        end

        $display("sent %0d items over several calibration sets, %0d results checked",
                 items_sent, results_seen);
        $display("%0d results flagged a zero divisor, %0d mismatches", errors_seen,
                 mismatches);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/bpc_pkg.sv
hdl/bpc_stream_if.sv
hdl/bpc_divider.sv
hdl/barometric_pressure_compensation.sv
tb/tb.sv
